[sv/utf8sv_pkg.sv]
// ----------------------------------------------------------------------------
// utf8sv_pkg
// Shared types and status codes for the UTF-8 sequence validator.
// ----------------------------------------------------------------------------
package utf8sv_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EOF      = 3'd1;
  localparam logic [2:0] ST_BADCONT  = 3'd2;
  localparam logic [2:0] ST_OVERLONG = 3'd3;
  localparam logic [2:0] ST_TOOBIG   = 3'd4;
  localparam logic [2:0] ST_BADSTART = 3'd5;

  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] LEAD_C0    = 8'hC0;
  localparam logic [7:0] LEAD_C2    = 8'hC2;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F5    = 8'hF5;
  localparam logic [7:0] LEAD_F8    = 8'hF8;
  localparam logic [7:0] OVL3_MASK  = 8'h20;
  localparam logic [7:0] OVL4_MASK  = 8'h30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_length;
  } out_t;

endpackage

[sv/utf8_sequence_validator_core.sv]
// ----------------------------------------------------------------------------
// utf8_sequence_validator_core
// Checks a UTF-8 byte stream and reports one status per sequence.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low and gives one status per
// sequence once the last byte of the sequence (or the end-of-buffer byte that
// cuts it short) is in. The sequence state is updated in the cycle a byte is
// taken and the status is registered into the output register, or into the
// skid register behind it while the output is stalled. The skid keeps the
// input side running for one more result while the output is stalled;
// in_stall is the registered skid-full flag. Continuation bytes inside a
// sequence that neither finish it nor end the buffer produce no transaction.
module utf8_sequence_validator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  utf8sv_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output utf8sv_pkg::out_t  out_data
);

  // sequence state
  logic [1:0] remaining_r, remaining_nxt;
  logic [2:0] total_len_r, total_len_nxt;
  logic       bad_r, bad_nxt;
  logic       ovl_r, ovl_nxt;
  logic       big_r, big_nxt;
  logic [3:0] low_r, low_nxt;

  // output register and skid
  logic             out_valid_r;
  utf8sv_pkg::out_t out_data_r;
  logic             skid_valid_r;
  utf8sv_pkg::out_t skid_data_r;

  logic             accept;
  logic             has_res;
  utf8sv_pkg::out_t res;
  logic [7:0]       b;
  logic             eob;
  logic [1:0]       need;
  logic [1:0]       rem_dec;
  logic [2:0]       idx;
  logic             bad_byte;

  assign accept = in_valid && !skid_valid_r;
  assign b      = in_data.data_byte;
  assign eob    = in_data.end_of_buffer;

  always_comb begin
    remaining_nxt = remaining_r;
    total_len_nxt = total_len_r;
    bad_nxt       = bad_r;
    ovl_nxt       = ovl_r;
    big_nxt       = big_r;
    low_nxt       = low_r;
    has_res       = 1'b0;
    res.status    = utf8sv_pkg::ST_OK;
    res.seq_length = 3'd0;
    need          = 2'd1;
    bad_byte      = (b < utf8sv_pkg::CONT_LO) || (b > utf8sv_pkg::CONT_HI);
    idx           = total_len_r - {1'b0, remaining_r};
    rem_dec       = remaining_r - 2'd1;

    if (remaining_r == 2'd0) begin
      if (b < utf8sv_pkg::CONT_LO) begin
        has_res        = 1'b1;
        res.seq_length = 3'd1;
      end else if (b < utf8sv_pkg::LEAD_C0) begin
        has_res    = 1'b1;
        res.status = utf8sv_pkg::ST_BADSTART;
      end else if (b < utf8sv_pkg::LEAD_C2) begin
        has_res    = 1'b1;
        res.status = utf8sv_pkg::ST_OVERLONG;
      end else if (b >= utf8sv_pkg::LEAD_F8) begin
        has_res    = 1'b1;
        res.status = utf8sv_pkg::ST_BADSTART;
      end else begin
        if (b < utf8sv_pkg::LEAD_E0) begin
          need = 2'd1;
        end else if (b < utf8sv_pkg::LEAD_F0) begin
          need = 2'd2;
        end else begin
          need = 2'd3;
        end
        if (eob) begin
          has_res    = 1'b1;
          res.status = utf8sv_pkg::ST_EOF;
        end else begin
          remaining_nxt = need;
          total_len_nxt = {1'b0, need} + 3'd1;
          bad_nxt       = 1'b0;
          ovl_nxt       = 1'b0;
          big_nxt       = (b >= utf8sv_pkg::LEAD_F5);
          low_nxt       = b[3:0];
        end
      end
    end else begin
      bad_nxt = bad_r | bad_byte;
      // overlong shows in the first continuation byte only
      if (idx == 3'd1) begin
        if (total_len_r == 3'd3 && low_r == 4'd0 &&
            (b & utf8sv_pkg::OVL3_MASK) == 8'd0) begin
          ovl_nxt = 1'b1;
        end
        if (total_len_r == 3'd4 && low_r[2:0] == 3'd0 &&
            (b & utf8sv_pkg::OVL4_MASK) == 8'd0) begin
          ovl_nxt = 1'b1;
        end
      end
      remaining_nxt = rem_dec;
      if (rem_dec != 2'd0) begin
        if (eob) begin
          has_res    = 1'b1;
          res.status = utf8sv_pkg::ST_EOF;
        end
      end else begin
        has_res = 1'b1;
        if (bad_nxt) begin
          res.status = utf8sv_pkg::ST_BADCONT;
        end else if (big_r) begin
          res.status = utf8sv_pkg::ST_TOOBIG;
        end else if (ovl_nxt) begin
          res.status = utf8sv_pkg::ST_OVERLONG;
        end else begin
          res.seq_length = total_len_r;
        end
      end
    end

    // any result resynchronizes at the next byte
    if (has_res) begin
      remaining_nxt = 2'd0;
      total_len_nxt = 3'd0;
      bad_nxt       = 1'b0;
      ovl_nxt       = 1'b0;
      big_nxt       = 1'b0;
      low_nxt       = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= 2'd0;
      total_len_r <= 3'd0;
      bad_r       <= 1'b0;
      ovl_r       <= 1'b0;
      big_r       <= 1'b0;
      low_r       <= 4'd0;
    end else if (accept) begin
      remaining_r <= remaining_nxt;
      total_len_r <= total_len_nxt;
      bad_r       <= bad_nxt;
      ovl_r       <= ovl_nxt;
      big_r       <= big_nxt;
      low_r       <= low_nxt;
    end
  end

  // output register with one skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r  <= skid_valid_r || (accept && has_res);
      skid_valid_r <= 1'b0;
    end else if (accept && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept && has_res) begin
        out_data_r <= res;
      end
    end else if (accept && has_res) begin
      skid_data_r <= res;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a length is reported exactly for ok sequences
  a_len_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.status == utf8sv_pkg::ST_OK) ==
                     (out_data_r.seq_length != 3'd0)))
    else $error("seq_length does not match status");

  // skid holds data only behind a full output register
  a_skid_behind : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid full with empty output register");

  // a pending sequence always has a length of two to four bytes
  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    remaining_r != 2'd0 |-> (total_len_r >= 3'd2 && total_len_r <= 3'd4 &&
                             {1'b0, remaining_r} < total_len_r))
    else $error("inconsistent sequence length state");

  // too-big leads only come from four-byte sequences
  a_big_len : assert property (@(posedge clk) disable iff (!rst_n)
    big_r |-> total_len_r == 3'd4)
    else $error("too-big flag on short sequence");

endmodule
